### sv/hmlf_pkg.sv
// Package: shared constants, types and key table for the HTTP length framer.
`default_nettype none
package hmlf_pkg;

   localparam int MAX_DIGITS_DEF  = 9;
   localparam int LENGTH_BITS_DEF = 32;

   localparam int KEY_LEN  = 15;
   localparam int KEY_W    = 4;
   localparam int VALUE_W  = 30;
   localparam int DIGIT_W  = 4;
   localparam int MSGLEN_W = 32;

   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   localparam logic [8*KEY_LEN-1:0] KEY_STR = "Content-Length:";

   typedef struct packed {
      logic [7:0]          out_byte;
      logic                in_body;
      logic                is_last;
      logic [MSGLEN_W-1:0] message_length;
      logic                length_error;
   } hmlf_result_type;

   function automatic logic [7:0] key_char(input logic [KEY_W-1:0] idx);
      logic [7:0] c;
      c = 8'h00;
      for (int i = 0; i < KEY_LEN; i++) begin
         if (idx == KEY_W'(i)) begin
            c = KEY_STR[8*(KEY_LEN-1-i) +: 8];
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

### sv/hmlf_parser.sv
// Parser: header scan, length gathering, body count and per-byte result.
`default_nettype none
module hmlf_parser #(
   parameter int MAX_DIGITS  = hmlf_pkg::MAX_DIGITS_DEF,
   parameter int LENGTH_BITS = hmlf_pkg::LENGTH_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     step,
   input  wire logic [7:0]               in_byte,
   output hmlf_pkg::hmlf_result_type     result
);
   import hmlf_pkg::*;

   localparam logic [1:0] BLK_NONE   = 2'd0;
   localparam logic [1:0] BLK_CR     = 2'd1;
   localparam logic [1:0] BLK_CRLF   = 2'd2;
   localparam logic [1:0] BLK_CRLFCR = 2'd3;

   localparam int EXT_W = (LENGTH_BITS > MSGLEN_W) ? LENGTH_BITS : MSGLEN_W + 1;

   logic [1:0]             blank_ff,     blank_in;
   logic [KEY_W-1:0]       key_prog_ff,  key_prog_in;
   logic                   key_found_ff, key_found_in;
   logic                   reading_ff,   reading_in;
   logic [VALUE_W-1:0]     length_ff,    length_in;
   logic [DIGIT_W-1:0]     digits_ff,    digits_in;
   logic                   body_ff,      body_in;
   logic [VALUE_W-1:0]     left_ff,      left_in;
   logic [LENGTH_BITS-1:0] seen_ff,      seen_in;
   logic                   ovf_ff,       ovf_in;

   always_comb begin
      logic             last;
      logic             blank_done;
      logic             is_digit;
      logic [KEY_W-1:0] kp;
      logic [EXT_W-1:0] seen_ext;
      logic [VALUE_W-1:0] left_dec;

      blank_in     = blank_ff;
      key_prog_in  = key_prog_ff;
      key_found_in = key_found_ff;
      reading_in   = reading_ff;
      length_in    = length_ff;
      digits_in    = digits_ff;
      body_in      = body_ff;
      left_in      = left_ff;
      ovf_in       = ovf_ff;
      last         = 1'b0;
      blank_done   = 1'b0;
      is_digit     = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
      kp           = key_prog_ff;
      left_dec     = left_ff;

      seen_in = (seen_ff != '1) ? seen_ff + 1'b1 : seen_ff;

      if (body_ff) begin
         if (left_ff != '0) begin
            left_dec = left_ff - 1'b1;
         end
         left_in = left_dec;
         if (left_dec == '0) begin
            last = 1'b1;
         end
      end else begin
         if (reading_ff) begin
            if (in_byte == CHAR_CR) begin
               reading_in = 1'b0;
            end else if (is_digit) begin
               if (digits_ff < DIGIT_W'(MAX_DIGITS)) begin
                  length_in = (length_ff << 3) + (length_ff << 1)
                            + VALUE_W'(in_byte - CHAR_ZERO);
                  digits_in = digits_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end else if (!key_found_ff) begin
            if (in_byte == key_char(key_prog_ff)) begin
               kp = key_prog_ff + 1'b1;
            end else begin
               kp = (in_byte == key_char('0)) ? KEY_W'(1) : '0;
            end
            if (kp >= KEY_W'(KEY_LEN)) begin
               key_found_in = 1'b1;
               reading_in   = 1'b1;
               kp           = '0;
            end
            key_prog_in = kp;
         end

         case (blank_ff)
            BLK_NONE: begin
               blank_in = (in_byte == CHAR_CR) ? BLK_CR : BLK_NONE;
            end
            BLK_CR: begin
               blank_in = (in_byte == CHAR_LF) ? BLK_CRLF :
                          ((in_byte == CHAR_CR) ? BLK_CR : BLK_NONE);
            end
            BLK_CRLF: begin
               blank_in = (in_byte == CHAR_CR) ? BLK_CRLFCR : BLK_NONE;
            end
            default: begin
               if (in_byte == CHAR_LF) begin
                  blank_done = 1'b1;
                  blank_in   = BLK_NONE;
               end else begin
                  blank_in = (in_byte == CHAR_CR) ? BLK_CR : BLK_NONE;
               end
            end
         endcase

         if (blank_done) begin
            if (key_found_in && length_in != '0) begin
               body_in = 1'b1;
               left_in = length_in;
            end else begin
               last = 1'b1;
            end
         end
      end

      seen_ext = EXT_W'(seen_in);
      result.out_byte       = in_byte;
      result.in_body        = body_ff;
      result.is_last        = last;
      result.length_error   = ovf_in;
      result.message_length = '0;
      if (last) begin
         result.message_length = (seen_ext > EXT_W'({MSGLEN_W{1'b1}})) ?
                                 {MSGLEN_W{1'b1}} : seen_ext[MSGLEN_W-1:0];
      end

      if (last) begin
         blank_in     = BLK_NONE;
         key_prog_in  = '0;
         key_found_in = 1'b0;
         reading_in   = 1'b0;
         length_in    = '0;
         digits_in    = '0;
         body_in      = 1'b0;
         left_in      = '0;
         seen_in      = '0;
         ovf_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blank_ff     <= BLK_NONE;
         key_prog_ff  <= '0;
         key_found_ff <= 1'b0;
         reading_ff   <= 1'b0;
         length_ff    <= '0;
         digits_ff    <= '0;
         body_ff      <= 1'b0;
         left_ff      <= '0;
         seen_ff      <= '0;
         ovf_ff       <= 1'b0;
      end else if (step) begin
         blank_ff     <= blank_in;
         key_prog_ff  <= key_prog_in;
         key_found_ff <= key_found_in;
         reading_ff   <= reading_in;
         length_ff    <= length_in;
         digits_ff    <= digits_in;
         body_ff      <= body_in;
         left_ff      <= left_in;
         seen_ff      <= seen_in;
         ovf_ff       <= ovf_in;
      end
   end

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      step && result.is_last |=> (seen_ff == '0) && !body_ff && !key_found_ff)
      else $error("state not cleared after last byte");

   a_body_needs_key: assert property (@(posedge clock) disable iff (reset)
      body_ff |-> key_found_ff && (left_ff != '0))
      else $error("body phase without key or remaining count");

   a_digit_bound: assert property (@(posedge clock) disable iff (reset)
      digits_ff <= DIGIT_W'(MAX_DIGITS))
      else $error("digit count beyond limit");

   a_key_prog_bound: assert property (@(posedge clock) disable iff (reset)
      key_prog_ff < KEY_W'(KEY_LEN))
      else $error("key match index out of range");

endmodule
`default_nettype wire

### sv/http_message_length_framer_top.sv
// Each req byte is held in the input register, then its result in the result register behind rsp_tvalid.
// One byte per cycle unless rsp_tready stalls; an empty input register takes req while a result waits.
// The parser state is one step of logic between the two registers.
// Reset (synchronous, active high) clears all parser state and both valid flags.
// No memory, no clearing pass: the block takes data in the first cycle after reset.
// Top level: stream ports, input and result registers around the parser.
`default_nettype none
module http_message_length_framer_top #(
   parameter int MAX_DIGITS  = hmlf_pkg::MAX_DIGITS_DEF,
   parameter int LENGTH_BITS = hmlf_pkg::LENGTH_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [7:0] out_byte, [39:8] message_length
   output logic [1:0]       rsp_tuser,   // [0] in_body, [1] length_error
   output logic             rsp_tlast    // is_last
);
   import hmlf_pkg::*;

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff,  in_byte_in;
   logic            out_valid_ff, out_valid_in;
   hmlf_result_type out_ff, out_in;
   hmlf_result_type res;
   logic            advance;
   logic            step;
   logic            req_take;

   assign advance    = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   hmlf_parser #(
      .MAX_DIGITS  (MAX_DIGITS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .in_byte (in_byte_ff),
      .result  (res)
   );

   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (step ? 1'b0 : in_valid_ff);
      in_byte_in   = req_take ? req_tdata : in_byte_ff;
      out_valid_in = step ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
      out_in       = step ? res : out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.message_length, out_ff.out_byte};
   assign rsp_tuser  = {out_ff.length_error, out_ff.in_body};
   assign rsp_tlast  = out_ff.is_last;

endmodule
`default_nettype wire
